/* hw/rtl/pbcs_pkg.sv */
`timescale 1ns / 1ps

// Shared types and constants for the plate box candidate selector.
package pbcs_pkg;

    // Coordinate and register widths.
    localparam int COORD_BITS = 12;
    localparam int DIM_BITS = 13;
    localparam int CFG_INDEX_BITS = 4;

    // Aspect error numerator |2h - w| needs one bit more than a coordinate.
    localparam int NUM_BITS = COORD_BITS + 1;
    localparam int AREA_BITS = 2 * COORD_BITS;
    localparam int FRAME_BITS = 2 * DIM_BITS;

    // Area bounds are compared as F < 30a and 6a + 6 <= F, so the compare
    // width must hold 30 times the largest area as well as the frame area.
    localparam int AREA_CMP_BITS = (2 * COORD_BITS + 5 > FRAME_BITS) ?
                                   2 * COORD_BITS + 6 : FRAME_BITS + 1;

    // Cross products of numerator and height, and the bound 10h.
    localparam int PROD_BITS = NUM_BITS + COORD_BITS;
    localparam int LIMIT_BITS = COORD_BITS + 4;

    // Centre compare covers both a coordinate and half a frame width.
    localparam int CENTRE_CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    // Decoupling queue; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [DIM_BITS-1:0]        dim_t;
    typedef logic [NUM_BITS-1:0]        num_t;
    typedef logic [AREA_BITS-1:0]       area_t;
    typedef logic [FRAME_BITS-1:0]      frame_t;
    typedef logic [AREA_CMP_BITS-1:0]   area_cmp_t;
    typedef logic [PROD_BITS-1:0]       prod_t;
    typedef logic [LIMIT_BITS-1:0]      limit_t;
    typedef logic [CENTRE_CMP_BITS-1:0] centre_cmp_t;
    typedef logic [CFG_INDEX_BITS-1:0]  cfg_index_t;
    typedef logic [QUEUE_PTR_BITS-1:0]  queue_ptr_t;
    typedef logic [QUEUE_PTR_BITS:0]    queue_count_t;

    // Register indexes and reset values.
    localparam cfg_index_t REG_IMAGE_WIDTH = cfg_index_t'(0);
    localparam cfg_index_t REG_IMAGE_HEIGHT = cfg_index_t'(1);
    localparam dim_t IMAGE_WIDTH_RESET = dim_t'(640);
    localparam dim_t IMAGE_HEIGHT_RESET = dim_t'(480);

    // Area divisors and the aspect error bound.
    localparam area_cmp_t AREA_LOW_DIV = area_cmp_t'(30);
    localparam area_cmp_t AREA_HIGH_DIV = area_cmp_t'(6);
    localparam limit_t ERROR_LIMIT = limit_t'(10);

    localparam queue_count_t QUEUE_FULL_COUNT = queue_count_t'(QUEUE_DEPTH);

    // One classified candidate, as passed from the front to the back.
    typedef struct packed {
        logic   qualify;
        logic   last;
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
        num_t   num;
    } cand_t;

    // Queue occupancy as seen by its two neighbours.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

/* hw/rtl/pbcs_front.sv */
`timescale 1ns / 1ps

// Front end: accepts boxes and classifies them in a three-stage pipeline.
module pbcs_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pbcs_pkg::coord_t       s_box_left,
    input  pbcs_pkg::coord_t       s_box_top,
    input  pbcs_pkg::coord_t       s_box_right,
    input  pbcs_pkg::coord_t       s_box_bottom,
    input  logic                   s_last_box,
    input  pbcs_pkg::dim_t         image_width,
    input  pbcs_pkg::dim_t         image_height,
    input  pbcs_pkg::queue_status_t q_status,
    output logic                   push,
    output pbcs_pkg::cand_t        cand
);

    // Stage one registers.
    logic             v1_reg;
    logic             last1_reg;
    logic             pre1_reg;
    pbcs_pkg::coord_t x1_reg, y1_reg, w1_reg, h1_reg;
    pbcs_pkg::num_t   num1_reg;

    // Stage two registers.
    logic             v2_reg;
    logic             last2_reg;
    logic             pre2_reg;
    pbcs_pkg::coord_t x2_reg, y2_reg, w2_reg, h2_reg;
    pbcs_pkg::num_t   num2_reg;
    pbcs_pkg::area_t  area2_reg;
    pbcs_pkg::frame_t frame2_reg;

    // Stage three registers.
    logic             v3_reg;
    pbcs_pkg::cand_t  cand3_reg;

    logic                 adv;
    pbcs_pkg::coord_t     w1_next, h1_next;
    pbcs_pkg::num_t       two_h, w_ext, num1_next;
    pbcs_pkg::dim_t       centre;
    logic                 pre1_next;
    pbcs_pkg::area_cmp_t  area_ext, frame_ext;
    logic                 qualify3_next;

    // The whole pipeline moves unless the last stage holds a beat the queue cannot take.
    assign adv = !v3_reg || !q_status.full;
    assign s_ready = adv;
    assign push = v3_reg && !q_status.full;
    assign cand = cand3_reg;

    // Size, aspect numerator and geometric checks of the incoming box.
    always_comb begin
        w1_next = s_box_right - s_box_left;
        h1_next = s_box_bottom - s_box_top;
        two_h = {h1_next, 1'b0};
        w_ext = {1'b0, w1_next};
        num1_next = (two_h >= w_ext) ? (two_h - w_ext) : (w_ext - two_h);
        centre = image_width >> 1;
        pre1_next = (s_box_right >= s_box_left) && (s_box_bottom >= s_box_top)
                    && (w1_next > h1_next)
                    && (pbcs_pkg::centre_cmp_t'(s_box_left) < pbcs_pkg::centre_cmp_t'(centre))
                    && (pbcs_pkg::centre_cmp_t'(s_box_right) > pbcs_pkg::centre_cmp_t'(centre));
    end

    // Area bounds without division: a > F/30 and a < F/6 in integer terms.
    always_comb begin
        area_ext = pbcs_pkg::area_cmp_t'(area2_reg);
        frame_ext = pbcs_pkg::area_cmp_t'(frame2_reg);
        qualify3_next = pre2_reg
            && (frame_ext < pbcs_pkg::area_cmp_t'(area_ext * pbcs_pkg::AREA_LOW_DIV))
            && (pbcs_pkg::area_cmp_t'(area_ext * pbcs_pkg::AREA_HIGH_DIV + pbcs_pkg::AREA_HIGH_DIV)
                <= frame_ext);
    end

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage payloads; the products are registered before the area compare.
    always_ff @(posedge aclk) begin
        if (adv) begin
            last1_reg <= s_last_box;
            pre1_reg <= pre1_next;
            x1_reg <= s_box_left;
            y1_reg <= s_box_top;
            w1_reg <= w1_next;
            h1_reg <= h1_next;
            num1_reg <= num1_next;

            last2_reg <= last1_reg;
            pre2_reg <= pre1_reg;
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            w2_reg <= w1_reg;
            h2_reg <= h1_reg;
            num2_reg <= num1_reg;
            area2_reg <= pbcs_pkg::area_t'(w1_reg) * pbcs_pkg::area_t'(h1_reg);
            frame2_reg <= pbcs_pkg::frame_t'(image_width) * pbcs_pkg::frame_t'(image_height);

            cand3_reg.qualify <= qualify3_next;
            cand3_reg.last <= last2_reg;
            cand3_reg.x <= x2_reg;
            cand3_reg.y <= y2_reg;
            cand3_reg.w <= w2_reg;
            cand3_reg.h <= h2_reg;
            cand3_reg.num <= num2_reg;
        end
    end

endmodule

/* hw/rtl/pbcs_queue.sv */
`timescale 1ns / 1ps

// Short queue of classified candidates between the front and the back.
module pbcs_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  pbcs_pkg::cand_t         push_data,
    input  logic                    pop,
    output pbcs_pkg::cand_t         head,
    output pbcs_pkg::queue_status_t status
);

    pbcs_pkg::cand_t        entry_reg [pbcs_pkg::QUEUE_DEPTH];
    pbcs_pkg::queue_ptr_t   wr_ptr_reg, rd_ptr_reg;
    pbcs_pkg::queue_count_t count_reg, count_next;

    assign head = entry_reg[rd_ptr_reg];
    assign status.full = (count_reg == pbcs_pkg::QUEUE_FULL_COUNT);
    assign status.valid = (count_reg != '0);

    // Occupancy follows pushes and pops in the same cycle.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/pbcs_back.sv */
`timescale 1ns / 1ps

// Back end: keeps the best candidate of the frame and emits the plate.
module pbcs_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pbcs_pkg::cand_t         head,
    input  pbcs_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output pbcs_pkg::coord_t        m_plate_x,
    output pbcs_pkg::coord_t        m_plate_y,
    output pbcs_pkg::coord_t        m_plate_width,
    output pbcs_pkg::coord_t        m_plate_height,
    output logic                    m_held_over
);

    // Frame winner and the previous plate.
    logic             have_best_reg, have_best_next;
    pbcs_pkg::coord_t best_x_reg, best_y_reg, best_w_reg, best_h_reg;
    pbcs_pkg::coord_t best_x_next, best_y_next, best_w_next, best_h_next;
    pbcs_pkg::num_t   best_num_reg, best_num_next;
    pbcs_pkg::coord_t prev_x_reg, prev_y_reg, prev_w_reg, prev_h_reg;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    pbcs_pkg::coord_t m_x_reg, m_y_reg, m_w_reg, m_h_reg;
    logic             m_held_reg;

    pbcs_pkg::prod_t  prod_new, prod_best;
    logic             better, take;

    assign m_valid = m_valid_reg;
    assign m_plate_x = m_x_reg;
    assign m_plate_y = m_y_reg;
    assign m_plate_width = m_w_reg;
    assign m_plate_height = m_h_reg;
    assign m_held_over = m_held_reg;

    // A last beat needs room in the output register; others always go through.
    assign pop = q_status.valid && (!head.last || !m_valid_reg || m_ready);

    // Exact error compare: n1/h1 < n2/h2 as n1*h2 < n2*h1.
    always_comb begin
        prod_new = pbcs_pkg::prod_t'(head.num) * pbcs_pkg::prod_t'(best_h_reg);
        prod_best = pbcs_pkg::prod_t'(best_num_reg) * pbcs_pkg::prod_t'(head.h);
        if (have_best_reg) begin
            better = prod_new < prod_best;
        end else begin
            better = pbcs_pkg::limit_t'(head.num)
                     < pbcs_pkg::limit_t'(pbcs_pkg::limit_t'(head.h) * pbcs_pkg::ERROR_LIMIT);
        end
        take = head.qualify && better;
    end

    // Winner including the candidate at the head.
    always_comb begin
        have_best_next = have_best_reg || take;
        best_x_next = take ? head.x : best_x_reg;
        best_y_next = take ? head.y : best_y_reg;
        best_w_next = take ? head.w : best_w_reg;
        best_h_next = take ? head.h : best_h_reg;
        best_num_next = take ? head.num : best_num_reg;
    end

    // The output register empties when taken and fills on a last beat.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (pop && head.last) begin
            m_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_w_reg <= '0;
            prev_h_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                have_best_reg <= have_best_next && !head.last;
                if (head.last && have_best_next) begin
                    prev_x_reg <= best_x_next;
                    prev_y_reg <= best_y_next;
                    prev_w_reg <= best_w_next;
                    prev_h_reg <= best_h_next;
                end
            end
        end
    end

    // Winner payload and the emitted plate.
    always_ff @(posedge aclk) begin
        if (pop) begin
            best_x_reg <= best_x_next;
            best_y_reg <= best_y_next;
            best_w_reg <= best_w_next;
            best_h_reg <= best_h_next;
            best_num_reg <= best_num_next;
            if (head.last) begin
                m_x_reg <= have_best_next ? best_x_next : prev_x_reg;
                m_y_reg <= have_best_next ? best_y_next : prev_y_reg;
                m_w_reg <= have_best_next ? best_w_next : prev_w_reg;
                m_h_reg <= have_best_next ? best_h_next : prev_h_reg;
                m_held_reg <= !have_best_next;
            end
        end
    end

`ifndef SYNTHESIS
    // A fresh winner is always wider than tall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_held_reg |-> m_w_reg > m_h_reg)
        else $error("emitted winner is not wider than tall");

    // The frame's winner is forgotten once the last box has been handled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head.last |=> !have_best_reg)
        else $error("winner survived the end of its frame");

    // A held winner keeps its aspect error under the bound.
    assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg |-> pbcs_pkg::limit_t'(best_num_reg)
            < pbcs_pkg::limit_t'(pbcs_pkg::limit_t'(best_h_reg) * pbcs_pkg::ERROR_LIMIT))
        else $error("held winner exceeds the aspect error bound");

    // A filled output register is only refilled once its beat has been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(pop && head.last))
        else $error("output register overwritten before hand-off");
`endif

endmodule

/* hw/rtl/plate_box_candidate_select.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | box_left, box_top, box_right, box_bottom, last_box
// m_        | out       | m_valid / m_ready  | plate_x, plate_y, plate_width, plate_height, held_over
// cfg_      | in        | cfg_wr_en          | cfg_addr (register index), cfg_wdata
//
// One box is taken per cycle unless the front stalls; a plate is offered once its frame's
// last box has passed three classify stages and the queue into the output register.
// The rate is set by the winner update, which compares one candidate per cycle.
// Reset is synchronous and active low; the registers return to 640 by 480.
// A stalled output holds back only last beats, and the front stalls once the queue is full.
module plate_box_candidate_select (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  pbcs_pkg::cfg_index_t cfg_addr,
    input  pbcs_pkg::dim_t       cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pbcs_pkg::coord_t     s_box_left,
    input  pbcs_pkg::coord_t     s_box_top,
    input  pbcs_pkg::coord_t     s_box_right,
    input  pbcs_pkg::coord_t     s_box_bottom,
    input  logic                 s_last_box,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pbcs_pkg::coord_t     m_plate_x,
    output pbcs_pkg::coord_t     m_plate_y,
    output pbcs_pkg::coord_t     m_plate_width,
    output pbcs_pkg::coord_t     m_plate_height,
    output logic                 m_held_over
);

    pbcs_pkg::dim_t          image_width_reg, image_height_reg;
    pbcs_pkg::cand_t         front_cand, queue_head;
    pbcs_pkg::queue_status_t q_status;
    logic                    push, pop;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= pbcs_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= pbcs_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pbcs_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata;
                end
                pbcs_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    pbcs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_box_left   (s_box_left),
        .s_box_top    (s_box_top),
        .s_box_right  (s_box_right),
        .s_box_bottom (s_box_bottom),
        .s_last_box   (s_last_box),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_status     (q_status),
        .push         (push),
        .cand         (front_cand)
    );

    pbcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cand),
        .pop       (pop),
        .head      (queue_head),
        .status    (q_status)
    );

    pbcs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (queue_head),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plate_x      (m_plate_x),
        .m_plate_y      (m_plate_y),
        .m_plate_width  (m_plate_width),
        .m_plate_height (m_plate_height),
        .m_held_over    (m_held_over)
    );

endmodule

/* sim/tb_plate_box_candidate_select.sv */
`timescale 1ns / 1ps

module tb_plate_box_candidate_select;

    localparam int CLOCK_HALF = 5;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int COORD_MAX = (1 << pbcs_pkg::COORD_BITS) - 1;

    // An index past the register list; writes to it must change nothing.
    localparam pbcs_pkg::cfg_index_t REG_SPARE = pbcs_pkg::cfg_index_t'(15);

    typedef struct {
        pbcs_pkg::coord_t left;
        pbcs_pkg::coord_t top;
        pbcs_pkg::coord_t right;
        pbcs_pkg::coord_t bottom;
        logic             last;
    } box_t;

    typedef struct {
        pbcs_pkg::coord_t x;
        pbcs_pkg::coord_t y;
        pbcs_pkg::coord_t width;
        pbcs_pkg::coord_t height;
        logic             held;
    } plate_t;

    // Selector model: tracks the frame's best box and the plates owed to the output.
    class plate_scoreboard;
        pbcs_pkg::dim_t img_w;
        pbcs_pkg::dim_t img_h;
        plate_t         best;
        pbcs_pkg::num_t best_num;
        bit             have_best;
        plate_t         prev;
        plate_t         pending[$];
        int             errors;
        int             boxes_seen;
        int             plates_checked;
        int             fresh_plates;
        int             held_plates;

        function new();
            img_w = pbcs_pkg::IMAGE_WIDTH_RESET;
            img_h = pbcs_pkg::IMAGE_HEIGHT_RESET;
            best = '{default: '0};
            prev = '{default: '0};
            best_num = '0;
            have_best = 1'b0;
            errors = 0;
            boxes_seen = 0;
            plates_checked = 0;
            fresh_plates = 0;
            held_plates = 0;
        endfunction

        function void set_register(pbcs_pkg::cfg_index_t idx, pbcs_pkg::dim_t value);
            case (idx)
                pbcs_pkg::REG_IMAGE_WIDTH: img_w = value;
                pbcs_pkg::REG_IMAGE_HEIGHT: img_h = value;
                default: ;
            endcase
        endfunction

        // Classify one accepted box and, on the frame's last box, queue its plate.
        function void note_box(box_t b);
            longint unsigned w, h, area, frame, centre, num;
            bit better;
            plate_t out;
            boxes_seen++;
            if (b.right >= b.left && b.bottom >= b.top) begin
                w = 64'(b.right) - 64'(b.left);
                h = 64'(b.bottom) - 64'(b.top);
                area = w * h;
                frame = 64'(img_w) * 64'(img_h);
                centre = 64'(img_w) / 2;
                if (w > h && area > frame / 64'(pbcs_pkg::AREA_LOW_DIV) &&
                        area < frame / 64'(pbcs_pkg::AREA_HIGH_DIV) &&
                        64'(b.left) < centre && 64'(b.right) > centre) begin
                    num = (2 * h >= w) ? 2 * h - w : w - 2 * h;
                    // Errors compare as fractions num / h by cross-multiplication.
                    if (have_best)
                        better = num * 64'(best.height) < 64'(best_num) * h;
                    else
                        better = num < 64'(pbcs_pkg::ERROR_LIMIT) * h;
                    if (better) begin
                        best = '{x: b.left, y: b.top, width: pbcs_pkg::coord_t'(w),
                                 height: pbcs_pkg::coord_t'(h), held: 1'b0};
                        best_num = pbcs_pkg::num_t'(num);
                        have_best = 1'b1;
                    end
                end
            end
            if (b.last) begin
                if (have_best) begin
                    prev = best;
                    out = best;
                    out.held = 1'b0;
                end else begin
                    out = prev;
                    out.held = 1'b1;
                end
                pending.push_back(out);
                best = '{default: '0};
                best_num = '0;
                have_best = 1'b0;
            end
        endfunction

        function void check_plate(plate_t got);
            plate_t want;
            if (pending.size() == 0) begin
                $error("plate beat arrived with no frame outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $error("plate_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("plate_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.width !== want.width) begin
                $error("plate_width: expected %0d, got %0d", want.width, got.width);
                errors++;
            end
            if (got.height !== want.height) begin
                $error("plate_height: expected %0d, got %0d", want.height, got.height);
                errors++;
            end
            if (got.held !== want.held) begin
                $error("held_over: expected %0d, got %0d", want.held, got.held);
                errors++;
            end
            plates_checked++;
            if (want.held)
                held_plates++;
            else
                fresh_plates++;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    pbcs_pkg::cfg_index_t cfg_addr = '0;
    pbcs_pkg::dim_t       cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pbcs_pkg::coord_t     s_box_left = '0;
    pbcs_pkg::coord_t     s_box_top = '0;
    pbcs_pkg::coord_t     s_box_right = '0;
    pbcs_pkg::coord_t     s_box_bottom = '0;
    logic                 s_last_box = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    pbcs_pkg::coord_t     m_plate_x;
    pbcs_pkg::coord_t     m_plate_y;
    pbcs_pkg::coord_t     m_plate_width;
    pbcs_pkg::coord_t     m_plate_height;
    logic                 m_held_over;

    plate_scoreboard board = new();
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;
    int quiet_cycles = 0;
    int phases_run = 0;
    int tx_calm = 0;

    plate_box_candidate_select u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_box_left     (s_box_left),
        .s_box_top      (s_box_top),
        .s_box_right    (s_box_right),
        .s_box_bottom   (s_box_bottom),
        .s_last_box     (s_last_box),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plate_x      (m_plate_x),
        .m_plate_y      (m_plate_y),
        .m_plate_width  (m_plate_width),
        .m_plate_height (m_plate_height),
        .m_held_over    (m_held_over)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #CLOCK_HALF aclk = ~aclk;
    end

    // Idle length for one side: mostly short, now and then long, with calm stretches.
    function automatic int idle_length(inout int calm_run);
        int roll;
        if (calm_run > 0) begin
            calm_run--;
            return 0;
        end
        if ($urandom_range(39, 0) == 0) begin
            calm_run = $urandom_range(80, 20);
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic box_t mk_box(int left, int top, int right, int bottom, bit last);
        box_t b;
        b.left = pbcs_pkg::coord_t'(left);
        b.top = pbcs_pkg::coord_t'(top);
        b.right = pbcs_pkg::coord_t'(right);
        b.bottom = pbcs_pkg::coord_t'(bottom);
        b.last = last;
        return b;
    endfunction

    // Build a box that should pass every test for the given frame size.
    function automatic bit make_candidate(input pbcs_pkg::dim_t iw, input pbcs_pkg::dim_t ih,
                                          output box_t b);
        longint unsigned frame, lo_area, hi_area, centre, h, w;
        longint unsigned wmin, wmax, lmin, lmax, hmax, left, top;
        b = '{default: '0};
        frame = 64'(iw) * 64'(ih);
        lo_area = frame / 64'(pbcs_pkg::AREA_LOW_DIV);
        hi_area = frame / 64'(pbcs_pkg::AREA_HIGH_DIV);
        centre = 64'(iw) / 2;
        hmax = (64'(ih) < COORD_MAX - 1) ? 64'(ih) : COORD_MAX - 1;
        if (hi_area < 2 || centre < 1 || hmax < 1)
            return 1'b0;
        for (int attempt = 0; attempt < 16; attempt++) begin
            h = $urandom_range(32'(hmax), 1);
            wmin = lo_area / h + 1;
            if (wmin < h + 1)
                wmin = h + 1;
            if (wmin < 2)
                wmin = 2;
            wmax = (hi_area - 1) / h;
            if (wmax > COORD_MAX)
                wmax = COORD_MAX;
            if (wmin > wmax)
                continue;
            // Half the time aim close to the ideal two-to-one shape.
            if ($urandom_range(1, 0) == 1) begin
                w = 2 * h + $urandom_range(3, 0);
                if (w > 3 && $urandom_range(1, 0) == 1)
                    w = w - 6;
                if (w < wmin)
                    w = wmin;
                if (w > wmax)
                    w = wmax;
            end else begin
                w = $urandom_range(32'(wmax), 32'(wmin));
            end
            lmin = (centre + 1 > w) ? centre + 1 - w : 0;
            lmax = (centre - 1 < COORD_MAX - w) ? centre - 1 : COORD_MAX - w;
            if (lmin > lmax)
                continue;
            left = $urandom_range(32'(lmax), 32'(lmin));
            top = $urandom_range(32'(COORD_MAX - h), 0);
            b.left = pbcs_pkg::coord_t'(left);
            b.right = pbcs_pkg::coord_t'(left + w);
            b.top = pbcs_pkg::coord_t'(top);
            b.bottom = pbcs_pkg::coord_t'(top + h);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one box after a random gap and hold it until the block takes it.
    task automatic send_box(input box_t b);
        int gap;
        gap = idle_length(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_box_left <= b.left;
        s_box_top <= b.top;
        s_box_right <= b.right;
        s_box_bottom <= b.bottom;
        s_last_box <= b.last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_box(b);
    endtask

    // Let every owed plate drain, then give the pipeline time to empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write per cycle; the enable is lowered once the burst is done.
    task automatic write_reg(input pbcs_pkg::cfg_index_t idx, input pbcs_pkg::dim_t value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_register(idx, value);
    endtask

    task automatic configure(input pbcs_pkg::dim_t width, input pbcs_pkg::dim_t height,
                             input bit poke_spare);
        settle();
        write_reg(pbcs_pkg::REG_IMAGE_WIDTH, width);
        write_reg(pbcs_pkg::REG_IMAGE_HEIGHT, height);
        if (poke_spare)
            write_reg(REG_SPARE, pbcs_pkg::dim_t'($urandom_range(8191, 0)));
        cfg_wr_en <= 1'b0;
    endtask

    // Random frames: mostly plausible plates, with ties and noise mixed in.
    task automatic run_phase(input pbcs_pkg::dim_t width, input pbcs_pkg::dim_t height,
                             input int budget, input bit poke_spare, input bit hold);
        int sent;
        int nboxes;
        int roll;
        int h;
        bit have_src;
        box_t b;
        box_t tie_src;
        configure(width, height, poke_spare);
        phases_run++;
        if (hold)
            hold_request = 1'b1;
        sent = 0;
        while (sent < budget) begin
            nboxes = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
            have_src = 1'b0;
            for (int i = 0; i < nboxes; i++) begin
                roll = $urandom_range(99, 0);
                if (roll < 15 && have_src) begin
                    // Same size elsewhere: equal error, so the earlier box must stay.
                    b = tie_src;
                    h = int'(tie_src.bottom) - int'(tie_src.top);
                    b.top = pbcs_pkg::coord_t'($urandom_range(COORD_MAX - h, 0));
                    b.bottom = pbcs_pkg::coord_t'(int'(b.top) + h);
                end else if (roll < 80 && make_candidate(width, height, b)) begin
                    tie_src = b;
                    have_src = 1'b1;
                end else begin
                    b = mk_box($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                               $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                               1'b0);
                end
                b.last = (i == nboxes - 1);
                send_box(b);
                sent++;
            end
        end
    endtask

    // Result side: random back-pressure plus one long hold while boxes keep coming.
    initial begin : plate_sink
        int stall_left;
        int rx_calm;
        plate_t got;
        stall_left = 0;
        rx_calm = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_plate_x, m_plate_y, m_plate_width, m_plate_height, m_held_over};
                board.check_plate(got);
            end
            if (hold_request && !hold_served) begin
                stall_left = LONG_HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = idle_length(rx_calm);
                m_ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: too long without any beat or register write means a hang.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed frames, then random phases over many frame sizes.
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Nothing qualifies straight after reset, so the all-zero plate is repeated.
        send_box(mk_box(0, 0, 0, 0, 1'b1));
        // A perfect two-to-one box, then an equal-error tie, closed by an inverted box.
        send_box(mk_box(200, 100, 400, 200, 1'b0));
        send_box(mk_box(250, 50, 450, 150, 1'b0));
        send_box(mk_box(COORD_MAX, 0, 0, 10, 1'b1));
        // A worse box replaced by a better one at the bottom edge.
        send_box(mk_box(250, 0, 430, 100, 1'b0));
        send_box(mk_box(300, COORD_MAX - 100, 500, COORD_MAX, 1'b1));
        // All coordinates at their maximum: empty box, previous plate held over.
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        // Bottom above top.
        send_box(mk_box(0, COORD_MAX, COORD_MAX, 0, 1'b1));
        // Area exactly at each bound, left on the centre, right on the centre, square.
        send_box(mk_box(300, 0, 460, 64, 1'b0));
        send_box(mk_box(100, 0, 420, 160, 1'b0));
        send_box(mk_box(320, 0, 520, 100, 1'b0));
        send_box(mk_box(120, 0, 320, 100, 1'b0));
        send_box(mk_box(250, 0, 400, 150, 1'b0));
        send_box(mk_box(300, 10, 450, 110, 1'b1));

        // Tiny frame: an aspect error of exactly ten is refused, nine is accepted.
        configure(40, 5, 1'b0);
        send_box(mk_box(10, 3, 22, 4, 1'b1));
        send_box(mk_box(10, 3, 21, 4, 1'b1));

        // Zero-height frame: area bounds collapse and nothing qualifies.
        configure(640, 0, 1'b1);
        send_box(mk_box(200, 100, 400, 200, 1'b0));
        send_box(mk_box(300, 10, 450, 110, 1'b1));

        run_phase(pbcs_pkg::IMAGE_WIDTH_RESET, pbcs_pkg::IMAGE_HEIGHT_RESET, 160, 1'b1, 1'b0);
        run_phase(4096, 4096, 200, 1'b0, 1'b1);
        run_phase(1, 1, 50, 1'b0, 1'b0);
        run_phase(4096, 1, 150, 1'b0, 1'b0);
        run_phase(1, 4096, 50, 1'b1, 1'b0);
        run_phase(0, 4096, 40, 1'b0, 1'b0);
        for (int p = 0; p < 5; p++)
            run_phase(pbcs_pkg::dim_t'($urandom_range(4096, 1)),
                      pbcs_pkg::dim_t'($urandom_range(4096, 1)), 170,
                      $urandom_range(1, 0), 1'b0);

        settle();
        $display("Covered %0d boxes over %0d frame sizes plus directed frames.",
                 board.boxes_seen, phases_run);
        $display("Plates checked: %0d (%0d fresh, %0d held over), mismatches: %0d.",
                 board.plates_checked, board.fresh_plates, board.held_plates, board.errors);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
